// File: rtl/core/lvm_pkg.sv
// Shared constants for the look-at view matrix pipeline.
// No dependencies; every other file imports this package.
package lvm_pkg;

  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned UNIT_W    = FRAC_BITS + 2;
  localparam int unsigned NORM_W    = 30;
  localparam int          NORM_TOP  = 29;
  localparam int unsigned ROW_W     = 2;

  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(3);
  localparam logic [WORD_BITS-1:0] FIX_ONE = WORD_BITS'(1) << FRAC_BITS;

endpackage

// File: rtl/core/lvm_if.sv
// Valid/ready channel interfaces for camera requests and matrix rows.
// Depends on lvm_pkg for field widths.
interface lvm_cam_if import lvm_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [WORD_BITS-1:0] cam_x, cam_y, cam_z;
  logic signed [WORD_BITS-1:0] target_x, target_y, target_z;
  logic signed [WORD_BITS-1:0] up_x, up_y, up_z;

  modport source (output valid, cam_x, cam_y, cam_z, target_x, target_y, target_z,
                  up_x, up_y, up_z, input ready);
  modport sink (input valid, cam_x, cam_y, cam_z, target_x, target_y, target_z,
                up_x, up_y, up_z, output ready);
endinterface

interface lvm_row_if import lvm_pkg::*; ();
  logic valid;
  logic ready;
  logic [ROW_W-1:0] row_index;
  logic signed [WORD_BITS-1:0] col_zero, col_one, col_two, col_three;
  logic degenerate;
  logic last_row;

  modport source (output valid, row_index, col_zero, col_one, col_two, col_three,
                  degenerate, last_row, input ready);
  modport sink (input valid, row_index, col_zero, col_one, col_two, col_three,
                degenerate, last_row, output ready);
endinterface

// File: rtl/core/lvm_norm.sv
// Pipelined vector normalizer: scale, sum of squares, square root, divide.
// Depends on lvm_pkg; one bit of root or quotient is resolved per stage.
module lvm_norm import lvm_pkg::*; #(
  parameter int unsigned IN_W   = 33,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [2:0][IN_W-1:0]        vec_i,
  input  logic [SIDE_W-1:0]           side_i,
  output logic                        valid_o,
  output logic [2:0][UNIT_W-1:0]      unit_o,
  output logic                        zero_o,
  output logic [SIDE_W-1:0]           side_o
);

  localparam int unsigned P_W    = $clog2(IN_W);
  localparam int unsigned GRP    = (IN_W + 7) / 8;
  localparam int unsigned PAD_W  = GRP * 8;
  localparam int unsigned EXT_W  = IN_W + NORM_W;
  localparam int unsigned SQ_W   = 2 * NORM_W;
  localparam int unsigned SUM_W  = 2 * NORM_W + 2;
  localparam int unsigned SQ_N   = NORM_W + 1;
  localparam int unsigned L_W    = NORM_W + 1;
  localparam int unsigned Q_W    = FRAC_BITS + 1;
  localparam int unsigned DIV_W  = NORM_W + FRAC_BITS + 1;
  localparam int unsigned NC     = SQ_N + 1 + Q_W;
  localparam int unsigned NV     = 7 + NC;

  typedef struct packed {
    logic [SIDE_W-1:0]         side;
    logic [2:0]                sg;
    logic                      zero;
    logic [2:0][NORM_W-1:0]    mm;
    logic [SUM_W-1:0]          x;
    logic [SUM_W-1:0]          r;
    logic [L_W-1:0]            len;
    logic [2:0][DIV_W-1:0]     rem;
    logic [2:0][Q_W-1:0]       q;
  } chain_t;

  logic [NV-1:0] vld_q;

  logic [2:0][IN_W-1:0]   m1_d, m1_q, m2_q, m3_q;
  logic [2:0]             sg1_d, sg1_q, sg2_q, sg3_q, sg4_q, sg5_q;
  logic [SIDE_W-1:0]      sd1_q, sd2_q, sd3_q, sd4_q, sd5_q;
  logic [GRP-1:0]         gnz_d, gnz_q;
  logic [GRP-1:0][2:0]    gpos_d, gpos_q;
  logic [P_W-1:0]         pos3_d, pos3_q;
  logic                   zero3_d, zero3_q, zero4_q, zero5_q;
  logic [2:0][NORM_W-1:0] mm4_d, mm4_q, mm5_q;
  logic [2:0][SQ_W-1:0]   sq5_d, sq5_q;
  chain_t                 s6_d;
  chain_t                 cq_q [NC+1];
  chain_t                 cd [1:NC];
  logic [2:0][UNIT_W-1:0] unit_d, unit_q;
  logic                   zero_q;
  logic [SIDE_W-1:0]      side_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sg1_d[c] = vec_i[c][IN_W-1];
      m1_d[c]  = sg1_d[c] ? (~vec_i[c] + IN_W'(1)) : vec_i[c];
    end
  end

  always_comb begin : grp_scan
    logic [PAD_W-1:0] orw;
    orw = PAD_W'(m1_q[0] | m1_q[1] | m1_q[2]);
    for (int g = 0; g < GRP; g++) begin
      gnz_d[g]  = |orw[g*8 +: 8];
      gpos_d[g] = 3'd0;
      for (int b = 0; b < 8; b++) begin
        if (orw[g*8 + b]) begin
          gpos_d[g] = 3'(b);
        end
      end
    end
  end

  always_comb begin
    zero3_d = ~(|gnz_q);
    pos3_d  = '0;
    for (int g = 0; g < GRP; g++) begin
      if (gnz_q[g]) begin
        pos3_d = P_W'(g * 8 + int'(gpos_q[g]));
      end
    end
  end

  always_comb begin : scale
    logic [EXT_W-1:0] ext;
    for (int c = 0; c < 3; c++) begin
      ext = EXT_W'(m3_q[c]);
      if (int'(pos3_q) > NORM_TOP) begin
        ext = ext >> (int'(pos3_q) - NORM_TOP);
      end else begin
        ext = ext << (NORM_TOP - int'(pos3_q));
      end
      mm4_d[c] = ext[NORM_W-1:0];
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sq5_d[c] = SQ_W'(mm4_q[c]) * SQ_W'(mm4_q[c]);
    end
  end

  always_comb begin
    s6_d      = '0;
    s6_d.side = sd5_q;
    s6_d.sg   = sg5_q;
    s6_d.zero = zero5_q;
    s6_d.mm   = mm5_q;
    s6_d.x    = SUM_W'(sq5_q[0]) + SUM_W'(sq5_q[1]) + SUM_W'(sq5_q[2]);
  end

  for (genvar k = 1; k <= SQ_N; k++) begin : g_sqrt
    localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (2 * (NORM_W - (k - 1)));
    always_comb begin
      cd[k] = cq_q[k-1];
      if (cq_q[k-1].x >= cq_q[k-1].r + BIT) begin
        cd[k].x = cq_q[k-1].x - (cq_q[k-1].r + BIT);
        cd[k].r = (cq_q[k-1].r >> 1) + BIT;
      end else begin
        cd[k].r = cq_q[k-1].r >> 1;
      end
    end
  end

  always_comb begin
    cd[SQ_N+1]     = cq_q[SQ_N];
    cd[SQ_N+1].len = cq_q[SQ_N].r[L_W-1:0];
    for (int c = 0; c < 3; c++) begin
      cd[SQ_N+1].rem[c] = (DIV_W'(cq_q[SQ_N].mm[c]) << FRAC_BITS)
                          + DIV_W'(cq_q[SQ_N].r[L_W-1:1]);
      cd[SQ_N+1].q[c]   = '0;
    end
  end

  for (genvar i = 0; i < Q_W; i++) begin : g_div
    localparam int K = SQ_N + 2 + i;
    localparam int B = Q_W - 1 - i;
    always_comb begin : div_step
      logic [DIV_W-1:0] dv;
      dv    = DIV_W'(cq_q[K-1].len) << B;
      cd[K] = cq_q[K-1];
      for (int c = 0; c < 3; c++) begin
        if (cq_q[K-1].rem[c] >= dv) begin
          cd[K].rem[c]  = cq_q[K-1].rem[c] - dv;
          cd[K].q[c][B] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (cq_q[NC].zero) begin
        unit_d[c] = '0;
      end else if (cq_q[NC].sg[c]) begin
        unit_d[c] = ~UNIT_W'(cq_q[NC].q[c]) + UNIT_W'(1);
      end else begin
        unit_d[c] = UNIT_W'(cq_q[NC].q[c]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NV-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m1_q    <= m1_d;
      sg1_q   <= sg1_d;
      sd1_q   <= side_i;
      gnz_q   <= gnz_d;
      gpos_q  <= gpos_d;
      m2_q    <= m1_q;
      sg2_q   <= sg1_q;
      sd2_q   <= sd1_q;
      pos3_q  <= pos3_d;
      zero3_q <= zero3_d;
      m3_q    <= m2_q;
      sg3_q   <= sg2_q;
      sd3_q   <= sd2_q;
      mm4_q   <= mm4_d;
      zero4_q <= zero3_q;
      sg4_q   <= sg3_q;
      sd4_q   <= sd3_q;
      sq5_q   <= sq5_d;
      mm5_q   <= mm4_q;
      zero5_q <= zero4_q;
      sg5_q   <= sg4_q;
      sd5_q   <= sd4_q;
      cq_q[0] <= s6_d;
      for (int k = 1; k <= NC; k++) begin
        cq_q[k] <= cd[k];
      end
      unit_q  <= unit_d;
      zero_q  <= cq_q[NC].zero;
      side_q  <= cq_q[NC].side;
    end
  end

  assign valid_o = vld_q[NV-1];
  assign unit_o  = unit_q;
  assign zero_o  = zero_q;
  assign side_o  = side_q;

endmodule

// File: rtl/core/lvm_cross.sv
// Two-stage cross product: six products, then three differences.
// Depends on lvm_pkg for its import convention only through the caller's widths.
module lvm_cross import lvm_pkg::*; #(
  parameter int unsigned A_W    = 32,
  parameter int unsigned B_W    = 18,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [2:0][A_W-1:0]        a_i,
  input  logic [2:0][B_W-1:0]        b_i,
  input  logic [SIDE_W-1:0]          side_i,
  output logic                       valid_o,
  output logic [2:0][A_W+B_W:0]      prod_o,
  output logic [SIDE_W-1:0]          side_o
);

  localparam int unsigned P_W = A_W + B_W;
  localparam int unsigned R_W = P_W + 1;

  logic [1:0]                vld_q;
  logic signed [P_W-1:0]     p_d [6];
  logic signed [P_W-1:0]     p_q [6];
  logic signed [R_W-1:0]     r_d [3];
  logic [2:0][R_W-1:0]       r_q;
  logic [SIDE_W-1:0]         sd1_q, sd2_q;

  always_comb begin
    p_d[0] = $signed(a_i[1]) * $signed(b_i[2]);
    p_d[1] = $signed(a_i[2]) * $signed(b_i[1]);
    p_d[2] = $signed(a_i[2]) * $signed(b_i[0]);
    p_d[3] = $signed(a_i[0]) * $signed(b_i[2]);
    p_d[4] = $signed(a_i[0]) * $signed(b_i[1]);
    p_d[5] = $signed(a_i[1]) * $signed(b_i[0]);
    for (int c = 0; c < 3; c++) begin
      r_d[c] = R_W'(p_q[2*c]) - R_W'(p_q[2*c+1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q   <= p_d;
      sd1_q <= side_i;
      for (int c = 0; c < 3; c++) begin
        r_q[c] <= r_d[c];
      end
      sd2_q <= sd1_q;
    end
  end

  assign valid_o = vld_q[1];
  assign prod_o  = r_q;
  assign side_o  = sd2_q;

endmodule

// File: rtl/core/lvm_out.sv
// Translation row (rounded, saturated, negated dot products) and row serializer.
// Depends on lvm_pkg; drives the pipeline advance enable.
module lvm_out import lvm_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [2:0][UNIT_W-1:0]      u_i,
  input  logic [2:0][UNIT_W-1:0]      v_i,
  input  logic [2:0][UNIT_W-1:0]      n_i,
  input  logic [2:0][WORD_BITS-1:0]   cam_i,
  input  logic                        degen_i,
  output logic                        adv_o,
  lvm_row_if.source                   row_o
);

  localparam int unsigned PR_W = UNIT_W + WORD_BITS;
  localparam int unsigned S_W  = PR_W + 2;
  localparam int unsigned R_W  = S_W + 1;
  localparam logic signed [R_W-1:0] SAT_HI = R_W'((64'd1 << (WORD_BITS - 1)) - 64'd1);
  localparam logic signed [R_W-1:0] SAT_LO = ~SAT_HI;

  typedef struct packed {
    logic [2:0][UNIT_W-1:0] u;
    logic [2:0][UNIT_W-1:0] v;
    logic [2:0][UNIT_W-1:0] n;
    logic                   degen;
  } basis_t;

  logic [2:0]                   vld_q;
  basis_t                       b1_q, b2_q, b3_q, hold_q;
  logic signed [PR_W-1:0]       pr_d [9];
  logic signed [PR_W-1:0]       pr_q [9];
  logic signed [S_W-1:0]        s_d [3];
  logic signed [S_W-1:0]        s_q [3];
  logic [2:0][WORD_BITS-1:0]    t_d, t_q, thold_q;
  logic                         busy_q;
  logic [ROW_W-1:0]             row_q;
  logic                         take, load;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      pr_d[c]   = $signed(u_i[c]) * $signed(cam_i[c]);
      pr_d[3+c] = $signed(v_i[c]) * $signed(cam_i[c]);
      pr_d[6+c] = $signed(n_i[c]) * $signed(cam_i[c]);
    end
    for (int j = 0; j < 3; j++) begin
      s_d[j] = S_W'(pr_q[3*j]) + S_W'(pr_q[3*j+1]) + S_W'(pr_q[3*j+2]);
    end
  end

  always_comb begin : round_sat
    logic [S_W-1:0]        mag;
    logic [S_W-1:0]        q;
    logic signed [R_W-1:0] r;
    for (int j = 0; j < 3; j++) begin
      mag = s_q[j][S_W-1] ? (~s_q[j] + S_W'(1)) : s_q[j];
      q   = (mag + (S_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      r   = s_q[j][S_W-1] ? $signed(R_W'(q)) : $signed(~R_W'(q) + R_W'(1));
      if (r > SAT_HI) begin
        t_d[j] = SAT_HI[WORD_BITS-1:0];
      end else if (r < SAT_LO) begin
        t_d[j] = SAT_LO[WORD_BITS-1:0];
      end else begin
        t_d[j] = r[WORD_BITS-1:0];
      end
    end
  end

  assign take  = busy_q && row_o.ready;
  assign load  = vld_q[2] && (!busy_q || (take && row_q == ROW_LAST));
  assign adv_o = !vld_q[2] || load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      busy_q <= 1'b0;
      row_q  <= '0;
    end else begin
      if (adv_o) begin
        vld_q <= {vld_q[1:0], valid_i};
      end
      if (load) begin
        busy_q <= 1'b1;
        row_q  <= '0;
      end else if (take) begin
        if (row_q == ROW_LAST) begin
          busy_q <= 1'b0;
        end
        row_q <= row_q + ROW_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      pr_q <= pr_d;
      b1_q <= '{u: u_i, v: v_i, n: n_i, degen: degen_i};
      s_q  <= s_d;
      b2_q <= b1_q;
      t_q  <= t_d;
      b3_q <= b2_q;
    end
    if (load) begin
      hold_q  <= b3_q;
      thold_q <= t_q;
    end
  end

  function automatic logic [WORD_BITS-1:0] widen(input logic [UNIT_W-1:0] x);
    return WORD_BITS'($signed(x));
  endfunction

  always_comb begin
    row_o.col_three = '0;
    case (row_q)
      2'd0: begin
        row_o.col_zero = widen(hold_q.u[0]);
        row_o.col_one  = widen(hold_q.v[0]);
        row_o.col_two  = widen(hold_q.n[0]);
      end
      2'd1: begin
        row_o.col_zero = widen(hold_q.u[1]);
        row_o.col_one  = widen(hold_q.v[1]);
        row_o.col_two  = widen(hold_q.n[1]);
      end
      2'd2: begin
        row_o.col_zero = widen(hold_q.u[2]);
        row_o.col_one  = widen(hold_q.v[2]);
        row_o.col_two  = widen(hold_q.n[2]);
      end
      default: begin
        row_o.col_zero  = thold_q[0];
        row_o.col_one   = thold_q[1];
        row_o.col_two   = thold_q[2];
        row_o.col_three = FIX_ONE;
      end
    endcase
  end

  assign row_o.valid      = busy_q;
  assign row_o.row_index  = row_q;
  assign row_o.degenerate = hold_q.degen;
  assign row_o.last_row   = (row_q == ROW_LAST);

endmodule

// File: rtl/core/lookat_view_matrix_top.sv
// Top level of the look-at view matrix generator.
// Depends on lvm_pkg, lvm_if, lvm_norm, lvm_cross and lvm_out.
//
//   Channel  Dir  Moves                       Handshake
//   cam_i    in   camera, target, up request  valid/ready
//   row_o    out  four rows per request       valid/ready
//
// Each request yields four rows, one per cycle while the row sink is ready; the row
// serializer limits how often requests are taken, loading a waiting request as the
// last row of the current one is taken. The path from the accepting edge to the first
// row runs mostly through the three normalizers, each resolving one root bit or one
// quotient bit per stage. All stages advance together; a stalled row sink freezes the
// pipeline once its last stage is full. Reset clears valid bits.
module lookat_view_matrix_top import lvm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  lvm_cam_if.sink   cam_i,
  lvm_row_if.source row_o
);

  localparam int unsigned D_W   = WORD_BITS + 1;
  localparam int unsigned U_W   = WORD_BITS + UNIT_W + 1;
  localparam int unsigned V_W   = 2 * UNIT_W + 1;
  localparam int unsigned CAM_W = 3 * WORD_BITS;
  localparam int unsigned VEC_W = 3 * UNIT_W;
  localparam int unsigned SD1_W = 2 * CAM_W;
  localparam int unsigned SD2_W = CAM_W + VEC_W + 1;
  localparam int unsigned SD3_W = CAM_W + 2 * VEC_W + 1;

  logic                       adv;
  logic                       v0_q;
  logic [2:0][WORD_BITS-1:0]  cam0_q, up0_q;
  logic [2:0][D_W-1:0]        d0_q;

  logic                       v1, v1x, v2, v2x, v3;
  logic [2:0][UNIT_W-1:0]     n1, u2, v3u;
  logic                       z1, z2, z3;
  logic [SD1_W-1:0]           sd1;
  logic [SD2_W-1:0]           sd1x, sd2;
  logic [SD3_W-1:0]           sd2x, sd3;
  logic [2:0][U_W-1:0]        ur;
  logic [2:0][V_W-1:0]        vr;
  logic [2:0][WORD_BITS-1:0]  cam1, up1, cam2, cam3;
  logic [2:0][UNIT_W-1:0]     n2, n2x, u2x, n3, u3;
  logic                       dg2, dg2x, dg3;

  assign cam_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (adv) begin
      v0_q <= cam_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cam0_q <= {cam_i.cam_z, cam_i.cam_y, cam_i.cam_x};
      up0_q  <= {cam_i.up_z, cam_i.up_y, cam_i.up_x};
      d0_q[0] <= D_W'(cam_i.cam_x) - D_W'(cam_i.target_x);
      d0_q[1] <= D_W'(cam_i.cam_y) - D_W'(cam_i.target_y);
      d0_q[2] <= D_W'(cam_i.cam_z) - D_W'(cam_i.target_z);
    end
  end

  lvm_norm #(.IN_W(D_W), .SIDE_W(SD1_W)) u_norm_n (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(v0_q), .vec_i(d0_q),
    .side_i({cam0_q, up0_q}), .valid_o(v1), .unit_o(n1), .zero_o(z1), .side_o(sd1)
  );

  assign {cam1, up1} = sd1;

  lvm_cross #(.A_W(WORD_BITS), .B_W(UNIT_W), .SIDE_W(SD2_W)) u_cross_u (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(v1), .a_i(up1), .b_i(n1),
    .side_i({cam1, n1, z1}), .valid_o(v1x), .prod_o(ur), .side_o(sd1x)
  );

  lvm_norm #(.IN_W(U_W), .SIDE_W(SD2_W)) u_norm_u (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(v1x), .vec_i(ur),
    .side_i(sd1x), .valid_o(v2), .unit_o(u2), .zero_o(z2), .side_o(sd2)
  );

  assign {cam2, n2, dg2} = sd2;

  lvm_cross #(.A_W(UNIT_W), .B_W(UNIT_W), .SIDE_W(SD3_W)) u_cross_v (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(v2), .a_i(n2), .b_i(u2),
    .side_i({cam2, n2, u2, dg2 | z2}), .valid_o(v2x), .prod_o(vr), .side_o(sd2x)
  );

  assign {n2x, u2x, dg2x} = sd2x[SD3_W-CAM_W-1:0];

  lvm_norm #(.IN_W(V_W), .SIDE_W(SD3_W)) u_norm_v (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(v2x), .vec_i(vr),
    .side_i({sd2x[SD3_W-1 -: CAM_W], n2x, u2x, dg2x}), .valid_o(v3), .unit_o(v3u),
    .zero_o(z3), .side_o(sd3)
  );

  assign {cam3, n3, u3, dg3} = sd3;

  lvm_out u_out (
    .clk_i, .rst_ni, .valid_i(v3), .u_i(u3), .v_i(v3u), .n_i(n3), .cam_i(cam3),
    .degen_i(dg3 | z3), .adv_o(adv), .row_o
  );

endmodule

// File: tb/lookat_view_matrix_top_test.sv
// Self-checking testbench for the look-at view matrix generator.
// Depends on lvm_pkg, lvm_if and lookat_view_matrix_top; predicts each row in a scoreboard.
module lookat_view_matrix_top_test import lvm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef longint vec3_t [3];
  typedef logic signed [WORD_BITS-1:0] word_t;

  typedef struct {
    word_t cam [3];
    word_t tgt [3];
    word_t up  [3];
  } camera_req_t;

  typedef struct {
    logic [ROW_W-1:0] row_index;
    word_t            col [4];
    logic             degenerate;
    logic             last_row;
  } matrix_row_t;

  class view_matrix_scoreboard;
    matrix_row_t rows_pending[$];
    int unsigned mismatches;
    int unsigned rows_seen;
    int unsigned degenerate_rows;

    static function longint unsigned magnitude(longint v);
      return v < 0 ? 64'd0 - longint'(v) : longint'(v);
    endfunction

    static function longint clamp_word(longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (WORD_BITS - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    static function longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    static function bit unit_vector(inout vec3_t v);
      longint unsigned m [3];
      longint unsigned mx;
      longint unsigned sum;
      longint unsigned len;
      longint unsigned q;
      mx = 0;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        m[i] = magnitude(v[i]);
        if (m[i] > mx) mx = m[i];
      end
      if (mx == 0) begin
        v = '{0, 0, 0};
        return 1'b1;
      end
      while (mx >= (64'd1 << 30)) begin
        mx = mx >> 1;
        for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
      end
      while (mx < (64'd1 << 29)) begin
        mx = mx << 1;
        for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
      end
      for (int i = 0; i < 3; i++) sum = sum + m[i] * m[i];
      len = int_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
        q = ((m[i] << FRAC_BITS) + (len >> 1)) / len;
        v[i] = v[i] < 0 ? -longint'(q) : longint'(q);
      end
      return 1'b0;
    endfunction

    static function void cross3(input vec3_t a, input vec3_t b, output vec3_t r);
      r[0] = a[1] * b[2] - a[2] * b[1];
      r[1] = a[2] * b[0] - a[0] * b[2];
      r[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    static function longint neg_dot(vec3_t a, vec3_t c);
      longint s;
      longint unsigned q;
      s = a[0] * c[0] + a[1] * c[1] + a[2] * c[2];
      q = (magnitude(s) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      return clamp_word(s < 0 ? longint'(q) : -longint'(q));
    endfunction

    function void note_request(camera_req_t req);
      vec3_t cam, up, n, u, v;
      longint dots [3];
      bit degen;
      matrix_row_t row;
      for (int i = 0; i < 3; i++) begin
        cam[i] = longint'(req.cam[i]);
        n[i]   = longint'(req.cam[i]) - longint'(req.tgt[i]);
        up[i]  = longint'(req.up[i]);
      end
      degen = unit_vector(n);
      cross3(up, n, u);
      degen |= unit_vector(u);
      cross3(n, u, v);
      degen |= unit_vector(v);
      dots[0] = neg_dot(u, cam);
      dots[1] = neg_dot(v, cam);
      dots[2] = neg_dot(n, cam);
      for (int i = 0; i < 4; i++) begin
        row.row_index  = ROW_W'(i);
        row.degenerate = degen;
        row.last_row   = (row.row_index == ROW_LAST);
        if (i < 3) begin
          row.col[0] = word_t'(clamp_word(u[i]));
          row.col[1] = word_t'(clamp_word(v[i]));
          row.col[2] = word_t'(clamp_word(n[i]));
          row.col[3] = '0;
        end else begin
          row.col[0] = word_t'(dots[0]);
          row.col[1] = word_t'(dots[1]);
          row.col[2] = word_t'(dots[2]);
          row.col[3] = FIX_ONE;
        end
        rows_pending.push_back(row);
      end
    endfunction

    function void check_row(matrix_row_t got);
      matrix_row_t exp;
      bit bad;
      rows_seen++;
      if (got.degenerate) degenerate_rows++;
      if (rows_pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected row %0d with no request pending", got.row_index);
        return;
      end
      exp = rows_pending.pop_front();
      bad = (got.row_index !== exp.row_index) || (got.degenerate !== exp.degenerate) ||
            (got.last_row !== exp.last_row);
      for (int i = 0; i < 4; i++) bad |= (got.col[i] !== exp.col[i]);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Row mismatch: expected row %0d cols %h %h %h %h degen %b last %b",
                   exp.row_index, exp.col[0], exp.col[1], exp.col[2], exp.col[3],
                   exp.degenerate, exp.last_row);
          $display("              actual   row %0d cols %h %h %h %h degen %b last %b",
                   got.row_index, got.col[0], got.col[1], got.col[2], got.col[3],
                   got.degenerate, got.last_row);
        end
      end
    endfunction
  endclass

  localparam int unsigned IDLE_LIMIT = 4000;

  logic clk_i;
  logic rst_ni;

  lvm_cam_if cam_bus ();
  lvm_row_if row_bus ();

  lookat_view_matrix_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cam_i  (cam_bus.sink),
    .row_o  (row_bus.source)
  );

  view_matrix_scoreboard board;
  bit          steady_mode;
  int unsigned requests_sent;
  int unsigned idle_cycles;

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  initial begin
    cam_bus.valid = 1'b0;
    {cam_bus.cam_x, cam_bus.cam_y, cam_bus.cam_z} = '0;
    {cam_bus.target_x, cam_bus.target_y, cam_bus.target_z} = '0;
    {cam_bus.up_x, cam_bus.up_y, cam_bus.up_z} = '0;
    row_bus.ready = 1'b0;
  end

  // Row sink stalls at random; in steady stretches it is always ready.
  always @(negedge clk_i) begin
    int unsigned stall;
    if (rst_ni) begin
      stall = pick_gap();
      if (stall == 0) begin
        row_bus.ready = 1'b1;
      end else begin
        row_bus.ready = 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    matrix_row_t got;
    if (rst_ni && row_bus.valid && row_bus.ready) begin
      got.row_index  = row_bus.row_index;
      got.col[0]     = row_bus.col_zero;
      got.col[1]     = row_bus.col_one;
      got.col[2]     = row_bus.col_two;
      got.col[3]     = row_bus.col_three;
      got.degenerate = row_bus.degenerate;
      got.last_row   = row_bus.last_row;
      board.check_row(got);
    end
  end

  always @(posedge clk_i) begin
    if ((cam_bus.valid && cam_bus.ready) || (row_bus.valid && row_bus.ready) || !rst_ni) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic send_request(camera_req_t req);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      cam_bus.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cam_bus.cam_x    = req.cam[0];
    cam_bus.cam_y    = req.cam[1];
    cam_bus.cam_z    = req.cam[2];
    cam_bus.target_x = req.tgt[0];
    cam_bus.target_y = req.tgt[1];
    cam_bus.target_z = req.tgt[2];
    cam_bus.up_x     = req.up[0];
    cam_bus.up_y     = req.up[1];
    cam_bus.up_z     = req.up[2];
    cam_bus.valid    = 1'b1;
    do @(posedge clk_i); while (!cam_bus.ready);
    board.note_request(req);
    requests_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_vectors(word_t cx, word_t cy, word_t cz, word_t tx, word_t ty,
                              word_t tz, word_t ux, word_t uy, word_t uz);
    camera_req_t req;
    req.cam = '{cx, cy, cz};
    req.tgt = '{tx, ty, tz};
    req.up  = '{ux, uy, uz};
    send_request(req);
  endtask

  function automatic word_t small_coord();
    return word_t'($signed($urandom_range(0, 32'h00400000)) - 32'sh00200000);
  endfunction

  function automatic word_t any_coord();
    return word_t'($urandom());
  endfunction

  task automatic send_random();
    camera_req_t req;
    int unsigned kind;
    kind = $urandom_range(0, 99);
    for (int i = 0; i < 3; i++) begin
      if (kind < 45) begin
        req.cam[i] = small_coord();
        req.tgt[i] = small_coord();
        req.up[i]  = small_coord();
      end else begin
        req.cam[i] = any_coord();
        req.tgt[i] = any_coord();
        req.up[i]  = any_coord();
      end
    end
    if (kind >= 90 && kind < 94) req.tgt = req.cam;
    if (kind >= 94 && kind < 97)
      for (int i = 0; i < 3; i++) req.up[i] = req.cam[i] - req.tgt[i];
    if (kind >= 97) req.up = '{0, 0, 0};
    send_request(req);
  endtask

  initial begin
    word_t mx;
    word_t mn;
    mx = {1'b0, {(WORD_BITS - 1){1'b1}}};
    mn = {1'b1, {(WORD_BITS - 1){1'b0}}};
    board = new();
    steady_mode = 1'b1;
    requests_sent = 0;
    idle_cycles = 0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_vectors(0, 0, 32'sh50000, 0, 0, 0, 0, FIX_ONE, 0);
    send_vectors(32'sh30000, 32'sh20000, 32'sh10000, 0, 0, 0, 0, 0, FIX_ONE);
    send_vectors(1, 2, 3, 1, 2, 3, 0, FIX_ONE, 0);
    send_vectors(0, 0, FIX_ONE, 0, 0, 0, 0, 0, FIX_ONE);
    send_vectors(0, 0, FIX_ONE, 0, 0, 0, 0, 0, 0);
    send_vectors(mx, mx, mx, mn, mn, mn, mx, mn, mx);
    send_vectors(mn, mn, mn, mx, mx, mx, mn, mx, mn);
    send_vectors(mx, mn, 0, mn, mx, 0, mx, mx, mx);
    send_vectors(mn, mn, mn, mn, mn, mn + 1, mn, mn, mn);
    send_vectors(1, 0, 0, 0, 0, 0, 0, 1, 0);
    send_vectors(-1, -1, -1, 0, 0, 0, 1, -1, 1);
    send_vectors(mx, 0, 0, mx - 1, 0, 0, 0, mx, 0);
    send_vectors(32'sh8000, 32'sh8000, 32'sh8000, 0, 0, 0, -1, 0, 0);
    send_vectors(32'h0000_FFFF, 32'hFFFF_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333,
                 32'hCCCC_CCCC, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h7FFF_0001);
    send_vectors(0, 0, 0, 0, 0, 0, 0, 0, 0);

    steady_mode = 1'b0;
    for (int k = 0; k < 445; k++) begin
      if (k % 100 == 60) steady_mode = 1'b1;
      if (k % 100 == 80) steady_mode = 1'b0;
      send_random();
    end
    cam_bus.valid = 1'b0;
    steady_mode = 1'b0;

    while (board.rows_pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    $display("Sent %0d camera requests and checked %0d rows, %0d of them flagged degenerate.",
             requests_sent, board.rows_seen, board.degenerate_rows);
    if (board.mismatches == 0 && board.rows_pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d rows missing", board.mismatches,
               board.rows_pending.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

// File: lookat_view_matrix_top.f
rtl/core/lvm_pkg.sv
rtl/core/lvm_if.sv
rtl/core/lvm_norm.sv
rtl/core/lvm_cross.sv
rtl/core/lvm_out.sv
rtl/core/lookat_view_matrix_top.sv
tb/lookat_view_matrix_top_test.sv
